>>> rtl/lfos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfos_pkg: shared types and constants of the line follower sequencer
// Field widths, register indexes and reset values, the phase encoding
// and the drive table that maps the three line bits to a motor command.
// ----------------------------------------------------------------------------
package lfos_pkg;

    // Widths
    localparam int TIMER_W    = 16;
    localparam int SPEED_W    = 7;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
    localparam logic [TIMER_W-1:0] TICK_MAX  = {TIMER_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_TICKS = 2'd3;

    // Register reset values
    localparam logic [SPEED_W-1:0] RST_DRIVE_SPEED   = 7'd100;
    localparam logic [TIMER_W-1:0] RST_OBSTACLE_WAIT = 16'd5000;
    localparam logic [TIMER_W-1:0] RST_TURN_TICKS    = 16'd1000;
    localparam logic [TIMER_W-1:0] RST_ADVANCE_TICKS = 16'd2000;

    // Reported phase codes
    localparam logic [PHASE_W-1:0] CODE_DRIVE = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_WAIT  = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_ROTL  = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_ADV1  = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_ROTR  = 3'd4;
    localparam logic [PHASE_W-1:0] CODE_ADV2  = 3'd5;
    localparam logic [PHASE_W-1:0] CODE_SEEK  = 3'd6;
    localparam logic [PHASE_W-1:0] CODE_DONE  = 3'd7;

    typedef enum logic [7:0] {
        PH_DRIVE = 8'b0000_0001,
        PH_WAIT  = 8'b0000_0010,
        PH_ROTL  = 8'b0000_0100,
        PH_ADV1  = 8'b0000_1000,
        PH_ROTR  = 8'b0001_0000,
        PH_ADV2  = 8'b0010_0000,
        PH_SEEK  = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } t_phase;

    // Sensor sample, left_line in the lowest bit
    typedef struct packed {
        logic stop_pressed;
        logic path_clear;
        logic right_line;
        logic middle_line;
        logic left_line;
    } t_sense;

    // Active register values, speed already limited to 100
    typedef struct packed {
        logic [SPEED_W-1:0] drive_speed;
        logic [TIMER_W-1:0] obstacle_wait_ticks;
        logic [TIMER_W-1:0] turn_ticks;
        logic [TIMER_W-1:0] advance_ticks;
    } t_cfg;

    // Motor command, left_forward in the lowest bit
    typedef struct packed {
        logic [PHASE_W-1:0] phase_now;
        logic [SPEED_W-1:0] right_speed;
        logic               right_forward;
        logic [SPEED_W-1:0] left_speed;
        logic               left_forward;
    } t_result;

    // Map the one-hot phase to its reported code
    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_DRIVE: code = CODE_DRIVE;
            PH_WAIT:  code = CODE_WAIT;
            PH_ROTL:  code = CODE_ROTL;
            PH_ADV1:  code = CODE_ADV1;
            PH_ROTR:  code = CODE_ROTR;
            PH_ADV2:  code = CODE_ADV2;
            PH_SEEK:  code = CODE_SEEK;
            default:  code = CODE_DONE;
        endcase
        return code;
    endfunction

    // Drive table: {left fwd, left runs, right fwd, right runs}, index l,m,r
    function automatic logic [3:0] drive_row(input logic [2:0] idx);
        logic [3:0] row;
        unique case (idx)
            3'b000:  row = 4'b1010;
            3'b001:  row = 4'b1110;
            3'b010:  row = 4'b1111;
            3'b011:  row = 4'b1101;
            3'b100:  row = 4'b1011;
            3'b101:  row = 4'b1010;
            3'b110:  row = 4'b0111;
            default: row = 4'b1010;
        endcase
        return row;
    endfunction

endpackage

>>> rtl/line_follower_obstacle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_obstacle_sequencer: line follower with obstacle detour
// One sensor sample per timer tick in, one motor command per sample out.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       sensor sample, tdata[4:0]
//  m_axis    out        m_axis_tvalid/tready       motor command, tdata[18:0]
//  cfg       in         i_cfg_valid/o_cfg_ready    register index, write data
//
//  One sample is taken every cycle while the output does not stall; each
//  sample passes through the input register, then the result register,
//  from which its motor command is offered on m_axis.
//  The sequencer state advances as a sample passes into the result register,
//  so a stalled output stalls the input only once both registers are full.
//  Reset puts the phase in driving, clears the tick counter and loads the
//  register defaults; config writes complete in the cycle they are offered.
// ----------------------------------------------------------------------------
module line_follower_obstacle_sequencer
    import lfos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sensor samples
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] left_line, [1] middle_line, [2] right_line, [3] path_clear,
    // [4] stop_pressed, [7:5] zero
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    // motor commands
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] left_forward, [7:1] left_speed, [8] right_forward,
    // [15:9] right_speed, [18:16] phase_now, [23:19] zero
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    r_in_valid;
    t_sense  r_in_sense;
    logic    r_out_valid;
    t_result r_out_result;
    logic    advance;
    t_cfg    cfg;
    t_result step_result;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    lfos_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Move a sample on when the result register is free or draining
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sense <= t_sense'(s_axis_tdata[4:0]);
        end
    end

    lfos_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (r_in_valid && advance),
        .i_sense  (r_in_sense),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W-$bits(t_result)){1'b0}}, r_out_result};

endmodule

>>> rtl/lfos_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfos_cfg_regs: configuration register bank
// Takes register writes from the config channel; limits the drive speed
// to 100 percent as it is stored.
// ----------------------------------------------------------------------------
module lfos_cfg_regs
    import lfos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic [SPEED_W-1:0] speed_in;

    // Limit the written speed to 100
    always_comb begin
        speed_in = i_wr_data[SPEED_W-1:0];
        if (speed_in > SPEED_MAX) begin
            speed_in = SPEED_MAX;
        end
    end

    // Decode the written register
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_DRIVE_SPEED:   n_cfg.drive_speed         = speed_in;
                REG_OBSTACLE_WAIT: n_cfg.obstacle_wait_ticks = i_wr_data[TIMER_W-1:0];
                REG_TURN_TICKS:    n_cfg.turn_ticks          = i_wr_data[TIMER_W-1:0];
                default:           n_cfg.advance_ticks       = i_wr_data[TIMER_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_speed         <= RST_DRIVE_SPEED;
            r_cfg.obstacle_wait_ticks <= RST_OBSTACLE_WAIT;
            r_cfg.turn_ticks          <= RST_TURN_TICKS;
            r_cfg.advance_ticks       <= RST_ADVANCE_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lfos_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfos_step: phase sequencer and motor command logic
// Holds the phase and tick counter; from one sensor sample computes the
// motor command and the next phase, committed when the sample is consumed.
// ----------------------------------------------------------------------------
module lfos_step
    import lfos_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_commit,
    input  t_sense  i_sense,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [TIMER_W-1:0] r_tick;
    logic [TIMER_W-1:0] n_tick;
    logic [TIMER_W-1:0] tick_inc;
    logic [TIMER_W-1:0] dur;
    logic [TIMER_W-1:0] dur_eff;
    logic               done;
    logic [3:0]         motors;
    logic [2:0]         line_idx;

    assign line_idx = {i_sense.left_line, i_sense.middle_line, i_sense.right_line};

    // Select the duration of the current timed phase
    always_comb begin
        unique case (r_phase)
            PH_WAIT:           dur = i_cfg.obstacle_wait_ticks;
            PH_ROTL, PH_ROTR:  dur = i_cfg.turn_ticks;
            PH_ADV1, PH_ADV2:  dur = i_cfg.advance_ticks;
            default:           dur = i_cfg.turn_ticks;
        endcase
    end

    // Count one tick, saturating at the top; a zero duration acts as one
    assign tick_inc = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign dur_eff  = (dur == '0) ? {{(TIMER_W-1){1'b0}}, 1'b1} : dur;
    assign done     = (tick_inc >= dur_eff);

    // Phase transitions and motor command
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        motors  = 4'b1010;
        unique case (r_phase)
            PH_DRIVE: begin
                priority if (i_sense.stop_pressed) begin
                    n_phase = PH_DONE;
                end else if (!i_sense.path_clear) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                end else begin
                    motors = drive_row(line_idx);
                end
            end
            PH_WAIT: begin
                n_tick = done ? '0 : tick_inc;
                if (done) begin
                    n_phase = i_sense.path_clear ? PH_DRIVE : PH_ROTL;
                end
            end
            PH_ROTL: begin
                motors = 4'b0111;
                n_tick = done ? '0 : tick_inc;
                if (done) begin
                    n_phase = PH_ADV1;
                end
            end
            PH_ADV1: begin
                motors = 4'b1111;
                n_tick = done ? '0 : tick_inc;
                if (done) begin
                    n_phase = PH_ROTR;
                end
            end
            PH_ROTR: begin
                motors = 4'b1101;
                n_tick = done ? '0 : tick_inc;
                if (done) begin
                    n_phase = PH_ADV2;
                end
            end
            PH_ADV2: begin
                motors = 4'b1111;
                n_tick = done ? '0 : tick_inc;
                if (done) begin
                    n_phase = PH_SEEK;
                end
            end
            PH_SEEK: begin
                motors = 4'b1111;
                if (line_idx != 3'b111) begin
                    n_phase = PH_DRIVE;
                    n_tick  = '0;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    // Build the result; a stopped motor reads forward at speed zero
    always_comb begin
        o_result.left_forward  = motors[3];
        o_result.left_speed    = motors[2] ? i_cfg.drive_speed : '0;
        o_result.right_forward = motors[1];
        o_result.right_speed   = motors[0] ? i_cfg.drive_speed : '0;
        o_result.phase_now     = phase_code(n_phase);
    end

    // Commit the state when the sample moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DRIVE;
            r_tick  <= '0;
        end else if (i_commit) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
        end
    end

endmodule

>>> rtl/lfos_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfos_checker: port-level checks of the line follower sequencer
// Watches the top-level ports; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module lfos_checker
    import lfos_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_DATA_W-1:0]   m_axis_tdata
);

    // Nothing is offered right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Speeds never exceed 100 percent
    a_speed_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] <= SPEED_MAX && m_axis_tdata[15:9] <= SPEED_MAX)
        else $error("speed above limit");

    // Waiting and finished phases keep both motors stopped
    a_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[18:16] == CODE_DONE
                          || m_axis_tdata[18:16] == CODE_WAIT)
        |-> m_axis_tdata[7:1] == '0 && m_axis_tdata[15:9] == '0
            && m_axis_tdata[0] && m_axis_tdata[8])
        else $error("motors running while stopped");

endmodule

bind line_follower_obstacle_sequencer lfos_checker u_lfos_checker (.*);

>>> sim/line_follower_obstacle_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_obstacle_sequencer_tb: self-checking bench for the sequencer
// Streams sensor samples into the block and checks every motor command
// against a cycle-free behavioral model kept in the bench. The run covers a
// directed pass through the drive table and one full detour, a longer wait
// with the speed register above its limit, several random register settings
// with short durations, and a final stop press. Both stream sides idle at
// random, the receiver holds off once for a long stretch, and registers
// change only while idle.
// ----------------------------------------------------------------------------
module line_follower_obstacle_sequencer_tb;
    import lfos_pkg::*;

    // Model state: register copies, current phase code, tick counter
    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [TIMER_W-1:0] wait_len;
        logic [TIMER_W-1:0] turn_len;
        logic [TIMER_W-1:0] adv_len;
        logic [PHASE_W-1:0] phase;
        logic [TIMER_W-1:0] ticks;
    } t_car_state;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_sense     sample_q[$];
    t_result    motor_cmd_q[$];
    t_sense     offered;
    t_result    got_cmd;
    t_result    want_cmd;
    t_car_state car_st;
    t_car_state plan_st;

    int         err_cnt        = 0;
    int         samples_sent   = 0;
    int         cmds_seen      = 0;
    int         reg_writes     = 0;
    int         hold_left      = 0;
    logic       long_hold_done = 1'b0;
    logic       src_idle_en    = 1'b1;
    logic       sink_idle_en   = 1'b1;
    logic [7:0] phases_hit     = '0;

    line_follower_obstacle_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Count one tick of a timed phase; true when the duration is reached
    function automatic logic timed_step(inout t_car_state st,
                                        input logic [TIMER_W-1:0] len);
        logic [TIMER_W-1:0] lim;
        lim = (len == '0) ? TIMER_W'(1) : len;
        if (st.ticks != TICK_MAX)
            st.ticks = st.ticks + 1'b1;
        if (st.ticks >= lim) begin
            st.ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the model by one tick and return the motor command it drives
    function automatic t_result drive_tick(inout t_car_state st, input t_sense s);
        t_result            r;
        logic [3:0]         cmd;    // {left fwd, left runs, right fwd, right runs}
        logic [SPEED_W-1:0] spd;
        spd = (st.speed > SPEED_MAX) ? SPEED_MAX : st.speed;
        cmd = 4'b1010;
        case (st.phase)
            CODE_DRIVE: begin
                if (s.stop_pressed) begin
                    st.phase = CODE_DONE;
                end else if (!s.path_clear) begin
                    st.phase = CODE_WAIT;
                    st.ticks = '0;
                end else begin
                    case ({s.left_line, s.middle_line, s.right_line})
                        3'b001:  cmd = 4'b1110;
                        3'b010:  cmd = 4'b1111;
                        3'b011:  cmd = 4'b1101;
                        3'b100:  cmd = 4'b1011;
                        3'b110:  cmd = 4'b0111;
                        default: cmd = 4'b1010;
                    endcase
                end
            end
            CODE_WAIT: begin
                if (timed_step(st, st.wait_len))
                    st.phase = s.path_clear ? CODE_DRIVE : CODE_ROTL;
            end
            CODE_ROTL: begin
                cmd = 4'b0111;
                if (timed_step(st, st.turn_len))
                    st.phase = CODE_ADV1;
            end
            CODE_ADV1: begin
                cmd = 4'b1111;
                if (timed_step(st, st.adv_len))
                    st.phase = CODE_ROTR;
            end
            CODE_ROTR: begin
                cmd = 4'b1101;
                if (timed_step(st, st.turn_len))
                    st.phase = CODE_ADV2;
            end
            CODE_ADV2: begin
                cmd = 4'b1111;
                if (timed_step(st, st.adv_len))
                    st.phase = CODE_SEEK;
            end
            CODE_SEEK: begin
                cmd = 4'b1111;
                if (!(s.left_line && s.middle_line && s.right_line)) begin
                    st.phase = CODE_DRIVE;
                    st.ticks = '0;
                end
            end
            default: st.phase = CODE_DONE;
        endcase
        r.left_forward  = cmd[3];
        r.left_speed    = cmd[2] ? spd : '0;
        r.right_forward = cmd[1];
        r.right_speed   = cmd[0] ? spd : '0;
        r.phase_now     = st.phase;
        return r;
    endfunction

    function automatic t_sense sense_of(input logic l, input logic m, input logic r,
                                        input logic clear, input logic stop);
        t_sense s;
        s.left_line    = l;
        s.middle_line  = m;
        s.right_line   = r;
        s.path_clear   = clear;
        s.stop_pressed = stop;
        return s;
    endfunction

    // Pick a random sample that keeps the car running, then advance the plan
    function automatic t_sense plan_sample(inout t_car_state g);
        t_sense  s;
        t_result unused;
        s = t_sense'(5'($urandom_range(31)));
        case (g.phase)
            CODE_DRIVE: begin
                s.stop_pressed = 1'b0;
                s.path_clear   = ($urandom_range(99) >= 7);
            end
            CODE_SEEK: begin
                if ($urandom_range(99) < 70)
                    {s.left_line, s.middle_line, s.right_line} = 3'b111;
            end
            default: ;
        endcase
        unused = drive_tick(g, s);
        return s;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Write one register and mirror it into the model once the transfer lands
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DRIVE_SPEED:   car_st.speed    = data[SPEED_W-1:0];
            REG_OBSTACLE_WAIT: car_st.wait_len = data[TIMER_W-1:0];
            REG_TURN_TICKS:    car_st.turn_len = data[TIMER_W-1:0];
            REG_ADVANCE_TICKS: car_st.adv_len  = data[TIMER_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] spd,
                                 input logic [CFG_DATA_W-1:0] wt,
                                 input logic [CFG_DATA_W-1:0] tt,
                                 input logic [CFG_DATA_W-1:0] at);
        write_reg(REG_DRIVE_SPEED, spd);
        write_reg(REG_OBSTACLE_WAIT, wt);
        write_reg(REG_TURN_TICKS, tt);
        write_reg(REG_ADVANCE_TICKS, at);
    endtask

    // Wait until every queued sample has gone in and every command came back
    task automatic drain;
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || motor_cmd_q.size() != 0);
    endtask

    task automatic run_random(input int count);
        plan_st = car_st;
        repeat (count) sample_q.push_back(plan_sample(plan_st));
        drain();
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Sample driver: predict on each transfer, then offer the next sample
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                motor_cmd_q.push_back(drive_tick(car_st, offered));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() != 0 && !(src_idle_en && $urandom_range(99) < 18)) begin
                    offered = sample_q.pop_front();
                    s_axis_tdata  <= {{(S_DATA_W - $bits(t_sense)){1'b0}}, offered};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Command monitor: compare each transfer, then pace tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_cmd = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                if (motor_cmd_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected command, expected none, actual %h",
                             $time, got_cmd);
                end else begin
                    want_cmd = motor_cmd_q.pop_front();
                    check_field("left_forward", int'(want_cmd.left_forward),
                                int'(got_cmd.left_forward));
                    check_field("left_speed", int'(want_cmd.left_speed),
                                int'(got_cmd.left_speed));
                    check_field("right_forward", int'(want_cmd.right_forward),
                                int'(got_cmd.right_forward));
                    check_field("right_speed", int'(want_cmd.right_speed),
                                int'(got_cmd.right_speed));
                    check_field("phase_now", int'(want_cmd.phase_now),
                                int'(got_cmd.phase_now));
                end
                phases_hit[got_cmd.phase_now] = 1'b1;
                cmds_seen++;
            end
            // hold off once for a long stretch so the block backs up
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && cmds_seen >= 200) begin
                long_hold_done <= 1'b1;
                hold_left      <= 300;
                m_axis_tready  <= 1'b0;
            end else begin
                m_axis_tready <= !(sink_idle_en && $urandom_range(99) < 18);
            end
        end
    end

    // Stimulus sequence
    initial begin
        car_st.speed    = RST_DRIVE_SPEED;
        car_st.wait_len = RST_OBSTACLE_WAIT;
        car_st.turn_len = RST_TURN_TICKS;
        car_st.adv_len  = RST_ADVANCE_TICKS;
        car_st.phase    = CODE_DRIVE;
        car_st.ticks    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every table row, wait of zero length, one full detour
        load_settings(16'd100, 16'd0, 16'd1, 16'd2);
        for (int i = 0; i < 8; i++)
            sample_q.push_back(sense_of(i[2], i[1], i[0], 1'b1, 1'b0));
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));  // obstacle seen
        sample_q.push_back(sense_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1));  // cleared, button ignored
        sample_q.push_back(sense_of(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));  // obstacle again
        sample_q.push_back(sense_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1));  // still there: detour
        sample_q.push_back(sense_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // rotate left
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));  // first advance
        sample_q.push_back(sense_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        sample_q.push_back(sense_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b1));  // rotate right
        sample_q.push_back(sense_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));  // second advance
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));  // seek, all white
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        sample_q.push_back(sense_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b0));  // line found
        drain();

        // Longer wait, speed above the limit; path clear at the recheck
        load_settings(16'hFFFF, 16'd40, 16'hFFFF, 16'hFFFF);
        sample_q.push_back(sense_of(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'b1, 1'b0));
        sample_q.push_back(sense_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        for (int k = 0; k < 40; k++)
            sample_q.push_back(sense_of(1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)),
                                        (k == 39) ? 1'b1 : 1'($urandom_range(1)),
                                        1'($urandom_range(1))));
        repeat (4)
            sample_q.push_back(sense_of(1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)), 1'b1, 1'b0));
        drain();

        // Random traffic over several settings, shortest durations first
        load_settings(16'd0, 16'd1, 16'd1, 16'd1);
        run_random(120);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        load_settings(16'd101, 16'd3, 16'd2, 16'd4);
        run_random(220);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        repeat (3) begin
            load_settings({9'($urandom_range(511)), 7'($urandom_range(127))},
                          16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                          16'($urandom_range(1, 12)));
            run_random(230);
        end

        // Stop press once back in driving; finished phase holds afterwards
        plan_st = car_st;
        while (plan_st.phase != CODE_DRIVE)
            sample_q.push_back(plan_sample(plan_st));
        sample_q.push_back(sense_of(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1));
        repeat (12) sample_q.push_back(t_sense'(5'($urandom_range(31))));
        drain();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d sensor samples and %0d motor commands across %0d register writes.",
                 samples_sent, cmds_seen, reg_writes);
        $display("Phase codes reported (one bit per code, 7 down to 0): %b", phases_hit);
        if (err_cnt == 0) begin
            $display("line_follower_obstacle_sequencer test passed");
        end else begin
            $display("line_follower_obstacle_sequencer test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("line_follower_obstacle_sequencer test failed");
        $finish;
    end

endmodule
